// ----- rtl/core/htw_pkg.sv -----
`default_nettype none

package htw_pkg;

    localparam int TIMER_COUNT_DEF = 64;
    localparam int BUCKET_BITS_DEF = 8;
    localparam int LEVELS_DEF      = 4;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_AFTER = 2'd1;
    localparam logic [1:0] STATUS_PENDING   = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_APP_RD,
        ST_APP_WR,
        ST_CAS_SEL,
        ST_CAS_RD,
        ST_CAS_HD,
        ST_CAS_TR,
        ST_CAS_TD,
        ST_FIRE_RD,
        ST_FIRE_HD,
        ST_DL_SCAN,
        ST_DL_RD,
        ST_DL_HD,
        ST_FIRE_TR,
        ST_FIRE_TD,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/htw_bucket_ram.sv -----
`default_nettype none

module htw_bucket_ram #(
    parameter int DEPTH  = 1024,
    parameter int SLOT_W = 10,
    parameter int PTR_W  = 7
) (
    input  wire logic              clk,
    input  wire logic              re,
    input  wire logic [SLOT_W-1:0] raddr,
    output logic      [PTR_W-1:0]  rhead,
    output logic      [PTR_W-1:0]  rtail,
    input  wire logic              we,
    input  wire logic [SLOT_W-1:0] waddr,
    input  wire logic [PTR_W-1:0]  whead,
    input  wire logic [PTR_W-1:0]  wtail
);

    logic [2*PTR_W-1:0] mem [DEPTH];
    logic [2*PTR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {whead, wtail};
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rhead = rdata_reg[2*PTR_W-1:PTR_W];
    assign rtail = rdata_reg[PTR_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/htw_timer_ram.sv -----
`default_nettype none

module htw_timer_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int PTR_W = 7
) (
    input  wire logic             clk,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [31:0]      rexp,
    output logic      [3:0]       rcode,
    output logic      [PTR_W-1:0] rlink,
    input  wire logic             we_entry,
    input  wire logic [AW-1:0]    waddr_entry,
    input  wire logic [31:0]      wexp,
    input  wire logic [3:0]       wcode,
    input  wire logic             we_link,
    input  wire logic [AW-1:0]    waddr_link,
    input  wire logic [PTR_W-1:0] wlink
);

    logic [35:0]      entry_mem [DEPTH];
    logic [PTR_W-1:0] link_mem  [DEPTH];
    logic [35:0]      entry_reg;
    logic [PTR_W-1:0] link_reg;

    always_ff @(posedge clk)
    begin
        if (we_entry)
        begin
            entry_mem[waddr_entry] <= {wexp, wcode};
        end
        if (re)
        begin
            entry_reg <= entry_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_link)
        begin
            link_mem[waddr_link] <= wlink;
        end
        if (re)
        begin
            link_reg <= link_mem[raddr];
        end
    end

    assign rexp  = entry_reg[35:4];
    assign rcode = entry_reg[3:0];
    assign rlink = link_reg;

endmodule

`default_nettype wire

// ----- rtl/core/hierarchical_timer_wheel_top.sv -----
`default_nettype none

// Hierarchical timing wheel: LEVELS levels of 2^BUCKET_BITS buckets over a pool of
// TIMER_COUNT timers and a wrapping 32-bit tick count. After reset all
// LEVELS*2^BUCKET_BITS bucket slots are swept to empty, during which in_ready stays low.
// One item is worked at a time. A set whose status is OK reads and rewrites its bucket,
// then emits its result. A tick cascades the due higher-level buckets, re-placing each
// of their timers, then fires the level-0 bucket timer by timer, recomputing the
// deadline from the busy words and the next level-1 bucket where needed. The bucket
// lists are walked one list link per step through the bucket and timer memories. A
// finished result waits in the output register while the next item is accepted.
module hierarchical_timer_wheel_top #(
    parameter int TIMER_COUNT = htw_pkg::TIMER_COUNT_DEF,
    parameter int BUCKET_BITS = htw_pkg::BUCKET_BITS_DEF,
    parameter int LEVELS      = htw_pkg::LEVELS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        operation,
    input  wire logic [5:0]  timer_id,
    input  wire logic [31:0] expiry_time,
    input  wire logic [3:0]  timer_kind,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [1:0]  status,
    output logic             fired,
    output logic      [5:0]  fired_timer_id,
    output logic      [3:0]  fired_kind,
    output logic      [31:0] current_time,
    output logic      [31:0] next_deadline,
    output logic             last
);

    localparam int IDW     = $clog2(TIMER_COUNT);
    localparam int PTR_W   = IDW + 1;
    localparam int BUCKETS = 1 << BUCKET_BITS;
    localparam int LVW     = (LEVELS > 2) ? 2 : 1;
    localparam int SLOT_W  = LVW + BUCKET_BITS;
    localparam int SLOTS   = LEVELS * BUCKETS;
    localparam int WORD_W  = (BUCKETS < 64) ? BUCKETS : 64;
    localparam int WORDS   = BUCKETS / WORD_W;
    localparam int WORD_IW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WBIT_W  = $clog2(WORD_W);
    localparam int GUARD_W = $clog2(TIMER_COUNT + 1);

    localparam logic [PTR_W-1:0]  EMPTY     = PTR_W'(TIMER_COUNT);
    localparam logic [LVW-1:0]    TOP_LVL   = LVW'(LEVELS - 1);
    localparam logic [LVW-1:0]    LVL0      = LVW'(0);
    localparam logic [LVW-1:0]    LVL1      = LVW'(1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    htw_pkg::state_t state_reg, state_next;

    logic [31:0]          now_reg, now_next;
    logic [31:0]          closest_reg, closest_next;
    logic [BUCKETS-1:0]   busy_reg, busy_next;
    logic [TIMER_COUNT-1:0] pending_reg, pending_next;
    logic                 op_reg, op_next;
    logic [1:0]           status_reg, status_next;
    logic [LVW-1:0]       lvl_reg, lvl_next;
    logic [LVW-1:0]       app_lvl_reg, app_lvl_next;
    logic [31:0]          app_t_reg, app_t_next;
    logic [IDW-1:0]       app_id_reg, app_id_next;
    logic [PTR_W-1:0]     cur_reg, cur_next;
    logic [GUARD_W-1:0]   guard_reg, guard_next;
    logic                 changed_reg, changed_next;
    logic [WORD_IW-1:0]   word_reg, word_next;
    logic [SLOT_W-1:0]    clr_reg, clr_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic        out_fired_reg, out_fired_next;
    logic [5:0]  out_id_reg, out_id_next;
    logic [3:0]  out_kind_reg, out_kind_next;
    logic [31:0] out_time_reg, out_time_next;
    logic [31:0] out_deadline_reg, out_deadline_next;
    logic        out_last_reg, out_last_next;

    // memory controls
    logic              b_re, b_we;
    logic [SLOT_W-1:0] b_raddr, b_waddr;
    logic [PTR_W-1:0]  b_whead, b_wtail, b_rhead, b_rtail;
    logic              t_re, t_we_e, t_we_l;
    logic [IDW-1:0]    t_raddr, t_waddr_e, t_waddr_l;
    logic [31:0]       t_wexp, t_rexp;
    logic [3:0]        t_wcode, t_rcode;
    logic [PTR_W-1:0]  t_wlink, t_rlink;

    logic              accept;
    logic              out_free;
    logic [IDW-1:0]    id_mod;
    logic [1:0]        set_status;
    logic [LVW-1:0]    set_lvl;
    logic [31:0]       now_inc;
    logic [31:0]       base;
    logic [WORD_W-1:0] busy_word;
    logic [31:0]       d_exp, d_close;

    function automatic logic [BUCKET_BITS-1:0] digit_of(input logic [31:0] t,
                                                        input logic [LVW-1:0] l);
        logic [31:0] sh;
        sh = t >> (BUCKET_BITS * l);
        return sh[BUCKET_BITS-1:0];
    endfunction

    function automatic logic [WBIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] v);
        logic [WBIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = WBIT_W'(i);
            end
        end
        return r;
    endfunction

    htw_bucket_ram #(
        .DEPTH  (SLOTS),
        .SLOT_W (SLOT_W),
        .PTR_W  (PTR_W)
    ) u_bucket_ram (
        .clk   (clk),
        .re    (b_re),
        .raddr (b_raddr),
        .rhead (b_rhead),
        .rtail (b_rtail),
        .we    (b_we),
        .waddr (b_waddr),
        .whead (b_whead),
        .wtail (b_wtail)
    );

    htw_timer_ram #(
        .DEPTH (TIMER_COUNT),
        .AW    (IDW),
        .PTR_W (PTR_W)
    ) u_timer_ram (
        .clk         (clk),
        .re          (t_re),
        .raddr       (t_raddr),
        .rexp        (t_rexp),
        .rcode       (t_rcode),
        .rlink       (t_rlink),
        .we_entry    (t_we_e),
        .waddr_entry (t_waddr_e),
        .wexp        (t_wexp),
        .wcode       (t_wcode),
        .we_link     (t_we_l),
        .waddr_link  (t_waddr_l),
        .wlink       (t_wlink)
    );

    assign in_ready  = (state_reg == htw_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign now_inc   = now_reg + 32'd1;
    assign base      = {now_reg[31:BUCKET_BITS], {BUCKET_BITS{1'b0}}};
    assign busy_word = busy_reg[word_reg * WORD_W +: WORD_W];
    assign d_exp     = expiry_time - now_reg;
    assign d_close   = expiry_time - closest_reg;

    // pool index, reduced modulo the pool size
    always_comb
    begin
        id_mod = '0;
        for (int k = 0; k < 64; k++)
        begin
            if (timer_id == 6'(k))
            begin
                id_mod = IDW'(k % TIMER_COUNT);
            end
        end
    end

    always_comb
    begin
        if (d_exp == 32'd0 || d_exp[31])
        begin
            set_status = htw_pkg::STATUS_NOT_AFTER;
        end
        else if (pending_reg[id_mod])
        begin
            set_status = htw_pkg::STATUS_PENDING;
        end
        else
        begin
            set_status = htw_pkg::STATUS_OK;
        end
    end

    // lowest level whose higher digits agree with the current time
    always_comb
    begin
        set_lvl = TOP_LVL;
        for (int w = LEVELS - 2; w >= 0; w--)
        begin
            if (((expiry_time ^ now_reg) >> (BUCKET_BITS * (w + 1))) == 32'd0)
            begin
                set_lvl = LVW'(w);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            htw_pkg::ST_CLEAR:
            begin
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = htw_pkg::ST_IDLE;
                end
            end
            htw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == htw_pkg::OP_SET)
                    begin
                        state_next = (set_status == htw_pkg::STATUS_OK) ?
                                     htw_pkg::ST_APP_RD : htw_pkg::ST_EMIT;
                    end
                    else if (digit_of(now_inc, LVL0) == '0)
                    begin
                        state_next = htw_pkg::ST_CAS_SEL;
                    end
                    else
                    begin
                        state_next = htw_pkg::ST_FIRE_RD;
                    end
                end
            end
            htw_pkg::ST_APP_RD:
            begin
                state_next = htw_pkg::ST_APP_WR;
            end
            htw_pkg::ST_APP_WR:
            begin
                state_next = (op_reg == htw_pkg::OP_SET) ? htw_pkg::ST_EMIT
                                                         : htw_pkg::ST_CAS_TR;
            end
            htw_pkg::ST_CAS_SEL:
            begin
                if ((now_reg & ((32'd1 << (BUCKET_BITS * lvl_reg)) - 32'd1)) == 32'd0)
                begin
                    state_next = htw_pkg::ST_CAS_RD;
                end
                else if (lvl_reg == LVL1)
                begin
                    state_next = htw_pkg::ST_FIRE_RD;
                end
            end
            htw_pkg::ST_CAS_RD:
            begin
                state_next = htw_pkg::ST_CAS_HD;
            end
            htw_pkg::ST_CAS_HD:
            begin
                state_next = htw_pkg::ST_CAS_TR;
            end
            htw_pkg::ST_CAS_TR:
            begin
                if (cur_reg == EMPTY || guard_reg == GUARD_W'(TIMER_COUNT))
                begin
                    state_next = (lvl_reg == LVL1) ? htw_pkg::ST_FIRE_RD
                                                   : htw_pkg::ST_CAS_SEL;
                end
                else
                begin
                    state_next = htw_pkg::ST_CAS_TD;
                end
            end
            htw_pkg::ST_CAS_TD:
            begin
                state_next = htw_pkg::ST_APP_RD;
            end
            htw_pkg::ST_FIRE_RD:
            begin
                state_next = htw_pkg::ST_FIRE_HD;
            end
            htw_pkg::ST_FIRE_HD:
            begin
                if ((closest_reg - now_reg) == 32'd0 || (closest_reg - now_reg) >= 32'h8000_0000
                    || changed_reg)
                begin
                    state_next = htw_pkg::ST_DL_SCAN;
                end
                else
                begin
                    state_next = htw_pkg::ST_FIRE_TR;
                end
            end
            htw_pkg::ST_DL_SCAN:
            begin
                if (busy_word != '0)
                begin
                    state_next = htw_pkg::ST_FIRE_TR;
                end
                else if (word_reg == WORD_IW'(WORDS - 1))
                begin
                    state_next = htw_pkg::ST_DL_RD;
                end
            end
            htw_pkg::ST_DL_RD:
            begin
                state_next = htw_pkg::ST_DL_HD;
            end
            htw_pkg::ST_DL_HD:
            begin
                state_next = htw_pkg::ST_FIRE_TR;
            end
            htw_pkg::ST_FIRE_TR:
            begin
                state_next = (cur_reg == EMPTY) ? htw_pkg::ST_EMIT : htw_pkg::ST_FIRE_TD;
            end
            htw_pkg::ST_FIRE_TD:
            begin
                if (out_free)
                begin
                    if (t_rlink == EMPTY || guard_reg == GUARD_W'(TIMER_COUNT - 1))
                    begin
                        state_next = htw_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = htw_pkg::ST_FIRE_TR;
                    end
                end
            end
            htw_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = htw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = htw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        now_next          = now_reg;
        closest_next      = closest_reg;
        busy_next         = busy_reg;
        pending_next      = pending_reg;
        op_next           = op_reg;
        status_next       = status_reg;
        lvl_next          = lvl_reg;
        app_lvl_next      = app_lvl_reg;
        app_t_next        = app_t_reg;
        app_id_next       = app_id_reg;
        cur_next          = cur_reg;
        guard_next        = guard_reg;
        changed_next      = changed_reg;
        word_next         = word_reg;
        clr_next          = clr_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_status_next   = out_status_reg;
        out_fired_next    = out_fired_reg;
        out_id_next       = out_id_reg;
        out_kind_next     = out_kind_reg;
        out_time_next     = out_time_reg;
        out_deadline_next = out_deadline_reg;
        out_last_next     = out_last_reg;

        b_re      = 1'b0;
        b_raddr   = '0;
        b_we      = 1'b0;
        b_waddr   = '0;
        b_whead   = EMPTY;
        b_wtail   = EMPTY;
        t_re      = 1'b0;
        t_raddr   = cur_reg[IDW-1:0];
        t_we_e    = 1'b0;
        t_waddr_e = id_mod;
        t_wexp    = expiry_time;
        t_wcode   = timer_kind;
        t_we_l    = 1'b0;
        t_waddr_l = app_id_reg;
        t_wlink   = EMPTY;

        unique case (state_reg)
            htw_pkg::ST_CLEAR:
            begin
                b_we     = 1'b1;
                b_waddr  = clr_reg;
                clr_next = clr_reg + SLOT_W'(1);
            end
            htw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next      = operation;
                    status_next  = htw_pkg::STATUS_OK;
                    changed_next = 1'b0;
                    lvl_next     = TOP_LVL;
                    if (operation == htw_pkg::OP_SET)
                    begin
                        status_next = set_status;
                        if (set_status == htw_pkg::STATUS_OK)
                        begin
                            t_we_e               = 1'b1;
                            pending_next[id_mod] = 1'b1;
                            if (d_close[31])
                            begin
                                closest_next = expiry_time;
                            end
                            app_lvl_next = set_lvl;
                            app_t_next   = expiry_time;
                            app_id_next  = id_mod;
                        end
                    end
                    else
                    begin
                        now_next = now_inc;
                    end
                end
            end
            htw_pkg::ST_APP_RD:
            begin
                b_re    = 1'b1;
                b_raddr = {app_lvl_reg, digit_of(app_t_reg, app_lvl_reg)};
                t_we_l  = 1'b1;
            end
            htw_pkg::ST_APP_WR:
            begin
                b_we    = 1'b1;
                b_waddr = {app_lvl_reg, digit_of(app_t_reg, app_lvl_reg)};
                b_whead = (b_rhead == EMPTY) ? PTR_W'(app_id_reg) : b_rhead;
                b_wtail = PTR_W'(app_id_reg);
                if (b_rhead != EMPTY)
                begin
                    t_we_l    = 1'b1;
                    t_waddr_l = b_rtail[IDW-1:0];
                    t_wlink   = PTR_W'(app_id_reg);
                end
                if (app_lvl_reg == LVL0)
                begin
                    busy_next[digit_of(app_t_reg, LVL0)] = 1'b1;
                end
            end
            htw_pkg::ST_CAS_SEL:
            begin
                if ((now_reg & ((32'd1 << (BUCKET_BITS * lvl_reg)) - 32'd1)) != 32'd0
                    && lvl_reg != LVL1)
                begin
                    lvl_next = lvl_reg - LVW'(1);
                end
            end
            htw_pkg::ST_CAS_RD:
            begin
                b_re    = 1'b1;
                b_raddr = {lvl_reg, digit_of(now_reg, lvl_reg)};
            end
            htw_pkg::ST_CAS_HD:
            begin
                // detach the due list; its timers are re-placed one by one
                b_we       = 1'b1;
                b_waddr    = {lvl_reg, digit_of(now_reg, lvl_reg)};
                cur_next   = b_rhead;
                guard_next = '0;
            end
            htw_pkg::ST_CAS_TR:
            begin
                if (cur_reg == EMPTY || guard_reg == GUARD_W'(TIMER_COUNT))
                begin
                    if (lvl_reg != LVL1)
                    begin
                        lvl_next = lvl_reg - LVW'(1);
                    end
                end
                else
                begin
                    t_re = 1'b1;
                end
            end
            htw_pkg::ST_CAS_TD:
            begin
                app_t_next  = t_rexp;
                app_id_next = cur_reg[IDW-1:0];
                cur_next    = t_rlink;
                guard_next  = guard_reg + GUARD_W'(1);
                if (((t_rexp ^ now_reg) >> (BUCKET_BITS * lvl_reg)) == 32'd0)
                begin
                    app_lvl_next = lvl_reg - LVW'(1);
                    if (lvl_reg == LVL1)
                    begin
                        changed_next = 1'b1;
                    end
                end
                else
                begin
                    app_lvl_next = lvl_reg;
                end
            end
            htw_pkg::ST_FIRE_RD:
            begin
                b_re    = 1'b1;
                b_raddr = {LVL0, digit_of(now_reg, LVL0)};
            end
            htw_pkg::ST_FIRE_HD:
            begin
                b_we       = 1'b1;
                b_waddr    = {LVL0, digit_of(now_reg, LVL0)};
                busy_next[digit_of(now_reg, LVL0)] = 1'b0;
                cur_next   = b_rhead;
                guard_next = '0;
                word_next  = WORD_IW'(digit_of(now_reg, LVL0) >> WBIT_W);
            end
            htw_pkg::ST_DL_SCAN:
            begin
                if (busy_word != '0)
                begin
                    closest_next = base + 32'(word_reg) * 32'(WORD_W)
                                   + 32'(lowest_bit(busy_word));
                end
                else if (word_reg != WORD_IW'(WORDS - 1))
                begin
                    word_next = word_reg + WORD_IW'(1);
                end
            end
            htw_pkg::ST_DL_RD:
            begin
                b_re    = 1'b1;
                b_raddr = {LVL1, digit_of(base + 32'(BUCKETS), LVL1)};
            end
            htw_pkg::ST_DL_HD:
            begin
                // nothing due in the next level-1 bucket: look a further span ahead
                closest_next = base + 32'(BUCKETS)
                               + ((b_rhead == EMPTY) ? 32'(BUCKETS) : 32'd0);
            end
            htw_pkg::ST_FIRE_TR:
            begin
                if (cur_reg != EMPTY)
                begin
                    t_re = 1'b1;
                end
            end
            htw_pkg::ST_FIRE_TD:
            begin
                if (out_free)
                begin
                    pending_next[cur_reg[IDW-1:0]] = 1'b0;
                    out_valid_next    = 1'b1;
                    out_status_next   = htw_pkg::STATUS_OK;
                    out_fired_next    = 1'b1;
                    out_id_next       = 6'(cur_reg[IDW-1:0]);
                    out_kind_next     = t_rcode;
                    out_time_next     = now_reg;
                    out_deadline_next = closest_reg;
                    out_last_next     = (t_rlink == EMPTY)
                                        || (guard_reg == GUARD_W'(TIMER_COUNT - 1));
                    cur_next          = t_rlink;
                    guard_next        = guard_reg + GUARD_W'(1);
                end
            end
            htw_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_status_next   = status_reg;
                    out_fired_next    = 1'b0;
                    out_id_next       = '0;
                    out_kind_next     = '0;
                    out_time_next     = now_reg;
                    out_deadline_next = closest_reg;
                    out_last_next     = 1'b1;
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= htw_pkg::ST_CLEAR;
            now_reg       <= '0;
            closest_reg   <= 32'(2 * BUCKETS);
            busy_reg      <= '0;
            pending_reg   <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            closest_reg   <= closest_next;
            busy_reg      <= busy_next;
            pending_reg   <= pending_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        status_reg       <= status_next;
        lvl_reg          <= lvl_next;
        app_lvl_reg      <= app_lvl_next;
        app_t_reg        <= app_t_next;
        app_id_reg       <= app_id_next;
        cur_reg          <= cur_next;
        guard_reg        <= guard_next;
        changed_reg      <= changed_next;
        word_reg         <= word_next;
        out_status_reg   <= out_status_next;
        out_fired_reg    <= out_fired_next;
        out_id_reg       <= out_id_next;
        out_kind_reg     <= out_kind_next;
        out_time_reg     <= out_time_next;
        out_deadline_reg <= out_deadline_next;
        out_last_reg     <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign fired          = out_fired_reg;
    assign fired_timer_id = out_id_reg;
    assign fired_kind     = out_kind_reg;
    assign current_time   = out_time_reg;
    assign next_deadline  = out_deadline_reg;
    assign last           = out_last_reg;

endmodule

`default_nettype wire
